// ===== hw/rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bitmap block allocator: sizes, status and opcode codes, result type.
// No dependencies; every other file of the block but bba_ram imports it.

package bba_pkg;

  // Map geometry.
  localparam int unsigned NUM_NODES     = 4096;
  localparam int unsigned MAP_WORD_BITS = 64;
  localparam int unsigned WORD_COUNT    = (NUM_NODES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WORD_AW       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BIT_AW        = $clog2(MAP_WORD_BITS);

  // Word search works on byte-sized chunks.
  localparam int unsigned CHUNK_BITS    = 8;
  localparam int unsigned CHUNK_LW      = 3;
  localparam int unsigned CHUNK_COUNT   = (MAP_WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned CHUNK_AW      = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int unsigned PAD_W         = CHUNK_COUNT * CHUNK_BITS;
  localparam int unsigned POS_W         = CHUNK_AW + CHUNK_LW;

  // Field widths and bit-number arithmetic widths.
  localparam int unsigned ID_W          = 13;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned BASE_W        = $clog2(WORD_COUNT * MAP_WORD_BITS + 1);
  localparam int unsigned CMP_W         = ((BASE_W > ID_W) ? BASE_W : ID_W) + 1;

  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);

  // Bits of the last word at or above NUM_NODES are forced to used.
  localparam int unsigned TAIL_BITS = NUM_NODES - (WORD_COUNT - 1) * MAP_WORD_BITS;
  localparam logic [MAP_WORD_BITS-1:0] WORD_ONE  = MAP_WORD_BITS'(1);
  localparam logic [MAP_WORD_BITS-1:0] TAIL_MASK = ~((WORD_ONE << TAIL_BITS) - WORD_ONE);

  // Padding bits above the word in the chunked view read as used.
  localparam logic [PAD_W-1:0] PAD_ONE  = PAD_W'(1);
  localparam logic [PAD_W-1:0] PAD_MASK = ~((PAD_ONE << MAP_WORD_BITS) - PAD_ONE);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BAD_ID = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    status_e         status;
  } rsp_t;

  // Write and read request to the map memory.
  typedef struct packed {
    logic                     we;
    logic [WORD_AW-1:0]       waddr;
    logic [MAP_WORD_BITS-1:0] wdata;
    logic [WORD_AW-1:0]       raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/bba_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the bitmap block allocator: valid/ready with opcode and block id.
// Depends on bba_pkg.

interface bba_req_if import bba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [ID_W-1:0] block_id;

  modport source (output valid, op, block_id, input ready);
  modport sink   (input valid, op, block_id, output ready);
endinterface

// ===== hw/rtl/bba_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the bitmap block allocator: valid/ready with granted id and status.
// Depends on bba_pkg.

interface bba_rsp_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     granted_id;
  logic [STATUS_W-1:0] status;

  modport source (output valid, granted_id, status, input ready);
  modport sink   (input valid, granted_id, status, output ready);
endinterface

// ===== hw/rtl/bba_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bba_ram #(
  parameter int unsigned DataWidth = 64,
  parameter int unsigned Depth     = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [DataWidth-1:0]                    wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [DataWidth-1:0]                    rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/bba_out_stage.sv =====
`timescale 1ns / 1ps
// One-entry output register that decouples the sequencer from the result receiver.
// Depends on bba_pkg.

module bba_out_stage import bba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rsp_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic valid_d, valid_q;
  rsp_t data_d, data_q;

  // Take a new result whenever the register is empty or is being drained.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        data_d = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/bba_core.sv =====
`timescale 1ns / 1ps
// Sequencer of the bitmap block allocator: word scan, two-step free-bit search and
// read-modify-write of the map. Depends on bba_pkg; drives the map RAM through ram_req_t.

module bba_core import bba_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic                     req_op_i,
  input  logic [ID_W-1:0]          req_block_id_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output rsp_t                     rsp_o,
  output ram_req_t                 ram_req_o,
  input  logic [MAP_WORD_BITS-1:0] ram_rdata_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_CHUNK = 7'b0000100,
    ST_PICK  = 7'b0001000,
    ST_FWALK = 7'b0010000,
    ST_FREAD = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e                   state_d, state_q;
  logic [WORD_AW-1:0]       rd_w_d, rd_w_q;
  logic [BASE_W-1:0]        rd_base_d, rd_base_q;
  logic                     chk_vld_d, chk_vld_q;
  logic [WORD_AW-1:0]       chk_w_d, chk_w_q;
  logic [BASE_W-1:0]        chk_base_d, chk_base_q;
  logic [MAP_WORD_BITS-1:0] word_d, word_q;
  logic [CHUNK_AW-1:0]      chunk_d, chunk_q;
  logic [CMP_W-1:0]         bidx_d, bidx_q;
  logic [WORD_COUNT-1:0]    word_valid_d, word_valid_q;
  rsp_t                     rsp_d, rsp_q;

  logic [MAP_WORD_BITS-1:0] rd_word;
  logic [MAP_WORD_BITS-1:0] scan_word;
  logic [PAD_W-1:0]         padded;
  logic [CHUNK_AW-1:0]      chunk_sel;
  logic [CHUNK_BITS-1:0]    chunk_bits;
  logic [CHUNK_LW-1:0]      bit_sel;
  logic [POS_W-1:0]         alloc_pos;
  logic [CMP_W-1:0]         grant_sum;
  logic [CMP_W-1:0]         free_diff;
  logic [BIT_AW-1:0]        free_pos;
  logic                     walk_hit;
  logic                     id_bad;

  // Map word as read: a word never written reads as all free.
  assign rd_word   = word_valid_q[chk_w_q] ? ram_rdata_i : '0;
  assign scan_word = rd_word | ((chk_w_q == LAST_WORD) ? TAIL_MASK : '0);

  // First step of the search: lowest chunk that holds a free bit.
  assign padded = PAD_MASK | PAD_W'(word_q);

  always_comb begin
    chunk_sel = '0;
    for (int c = CHUNK_COUNT - 1; c >= 0; c--) begin
      if (!(&padded[c*CHUNK_BITS +: CHUNK_BITS])) begin
        chunk_sel = CHUNK_AW'(c);
      end
    end
  end

  // Second step: lowest free bit inside the chosen chunk.
  assign chunk_bits = padded[chunk_q*CHUNK_BITS +: CHUNK_BITS];

  always_comb begin
    bit_sel = '0;
    for (int k = CHUNK_BITS - 1; k >= 0; k--) begin
      if (!chunk_bits[k]) begin
        bit_sel = CHUNK_LW'(k);
      end
    end
  end

  assign alloc_pos = {chunk_q, bit_sel};
  assign grant_sum = CMP_W'(chk_base_q) + CMP_W'(alloc_pos) + CMP_W'(1);

  // Free path: walk word bases until the target bit falls inside the word.
  assign walk_hit  = bidx_q < (CMP_W'(rd_base_q) + CMP_W'(MAP_WORD_BITS));
  assign free_diff = bidx_q - CMP_W'(chk_base_q);
  assign free_pos  = free_diff[BIT_AW-1:0];
  assign id_bad    = (req_block_id_i == '0) || (CMP_W'(req_block_id_i) > CMP_W'(NUM_NODES));

  always_comb begin
    state_d      = state_q;
    rd_w_d       = rd_w_q;
    rd_base_d    = rd_base_q;
    chk_vld_d    = chk_vld_q;
    chk_w_d      = chk_w_q;
    chk_base_d   = chk_base_q;
    word_d       = word_q;
    chunk_d      = chunk_q;
    bidx_d       = bidx_q;
    word_valid_d = word_valid_q;
    rsp_d        = rsp_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = chk_w_q;
    ram_req_o.wdata = '0;
    ram_req_o.raddr = rd_w_q;

    case (state_q)
      ST_IDLE: begin
        rd_w_d    = '0;
        rd_base_d = '0;
        chk_vld_d = 1'b0;
        bidx_d    = CMP_W'(req_block_id_i) - CMP_W'(1);
        if (req_valid_i) begin
          if (req_op_i == OP_ALLOC) begin
            state_d = ST_SCAN;
          end else if (id_bad) begin
            rsp_d   = '{granted_id: '0, status: STATUS_BAD_ID};
            state_d = ST_DONE;
          end else begin
            state_d = ST_FWALK;
          end
        end
      end

      // One word read issued and one word checked per cycle.
      ST_SCAN: begin
        if (rd_w_q != LAST_WORD) begin
          rd_w_d    = rd_w_q + WORD_AW'(1);
          rd_base_d = rd_base_q + BASE_W'(MAP_WORD_BITS);
        end
        chk_vld_d  = 1'b1;
        chk_w_d    = rd_w_q;
        chk_base_d = rd_base_q;
        if (chk_vld_q) begin
          if (!(&scan_word)) begin
            word_d     = scan_word;
            chk_w_d    = chk_w_q;
            chk_base_d = chk_base_q;
            state_d    = ST_CHUNK;
          end else if (chk_w_q == LAST_WORD) begin
            rsp_d   = '{granted_id: '0, status: STATUS_FULL};
            state_d = ST_DONE;
          end
        end
      end

      ST_CHUNK: begin
        chunk_d = chunk_sel;
        state_d = ST_PICK;
      end

      // Mark the found bit used and report its id.
      ST_PICK: begin
        ram_req_o.we          = 1'b1;
        ram_req_o.wdata       = word_q | (WORD_ONE << alloc_pos);
        word_valid_d[chk_w_q] = 1'b1;
        rsp_d                 = '{granted_id: grant_sum[ID_W-1:0], status: STATUS_OK};
        state_d               = ST_DONE;
      end

      ST_FWALK: begin
        if (walk_hit) begin
          chk_w_d    = rd_w_q;
          chk_base_d = rd_base_q;
          state_d    = ST_FREAD;
        end else begin
          rd_w_d    = rd_w_q + WORD_AW'(1);
          rd_base_d = rd_base_q + BASE_W'(MAP_WORD_BITS);
        end
      end

      // Target word has arrived: clear the bit and write it back.
      ST_FREAD: begin
        ram_req_o.we          = 1'b1;
        ram_req_o.wdata       = rd_word & ~(WORD_ONE << free_pos);
        word_valid_d[chk_w_q] = 1'b1;
        rsp_d                 = '{granted_id: '0, status: STATUS_OK};
        state_d               = ST_DONE;
      end

      ST_DONE: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_DONE);
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      chk_vld_q    <= 1'b0;
      word_valid_q <= '0;
    end else begin
      state_q      <= state_d;
      chk_vld_q    <= chk_vld_d;
      word_valid_q <= word_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_w_q     <= rd_w_d;
    rd_base_q  <= rd_base_d;
    chk_w_q    <= chk_w_d;
    chk_base_q <= chk_base_d;
    word_q     <= word_d;
    chunk_q    <= chunk_d;
    bidx_q     <= bidx_d;
    rsp_q      <= rsp_d;
  end

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// Bitmap block allocator, first fit: used/free map in a RAM of MAP_WORD_BITS-bit words.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ram, bba_core and bba_out_stage.
//
// Usage:
// - req_i carries one request per transaction: op allocate with block_id ignored, or op
//   free with a 1-based block_id. rsp_o returns exactly one result per request, in order.
// - Allocate returns the lowest free id and status ok, or id 0 and status full.
//   Free returns id 0 and status ok, or status bad id for id 0 or above NUM_NODES.
// - The block works on one request at a time; req_i.ready is high only while idle.
// - Allocate scans the map one word per cycle through the RAM read port, then finds
//   the free bit by byte, then by bit.
// - Free walks the word bases one per cycle, then reads, clears and writes back the
//   word; a bad id is answered without touching the map.
// - A result waits in an output register while rsp_o is stalled; the sequencer can
//   take the next request meanwhile and holds its own result until the register frees.
// - Reset clears the per-word valid bits, so every block reads free right away;
//   no clearing pass over the RAM is needed.

module bitmap_block_allocator import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);

  ram_req_t                 ram_req;
  logic [MAP_WORD_BITS-1:0] ram_rdata;
  logic                     core_valid;
  logic                     core_ready;
  rsp_t                     core_rsp;
  rsp_t                     out_rsp;

  // Sequencer.
  bba_core u_core (
    .clk_i,
    .rst_ni,
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_op_i       (req_i.op),
    .req_block_id_i (req_i.block_id),
    .rsp_valid_o    (core_valid),
    .rsp_ready_i    (core_ready),
    .rsp_o          (core_rsp),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata)
  );

  // Map storage.
  bba_ram #(
    .DataWidth (MAP_WORD_BITS),
    .Depth     (WORD_COUNT)
  ) u_map_ram (
    .clk_i,
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output register.
  bba_out_stage u_out_stage (
    .clk_i,
    .rst_ni,
    .in_valid_i  (core_valid),
    .in_ready_o  (core_ready),
    .in_data_i   (core_rsp),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (out_rsp)
  );

  assign rsp_o.granted_id = out_rsp.granted_id;
  assign rsp_o.status     = out_rsp.status;

endmodule

// ===== hw/rtl/bba_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.

module bba_checker import bba_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [ID_W-1:0]     granted_id_i,
  input logic [STATUS_W-1:0] status_i
);

  // No result can be pending while the block is held in reset.
  assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("result valid during reset");

  // A failed request never carries a granted id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (status_i != STATUS_OK)) |-> (granted_id_i == '0))
    else $error("granted id on a failed request");

  // The block works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while another is in progress");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(granted_id_i) && $stable(status_i)))
    else $error("stalled result changed");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .granted_id_i (rsp_o.granted_id),
  .status_i     (rsp_o.status)
);
